>>> rtl/n7s_pkg.sv
// Shared types, segment codes and the hex segment table for the number formatter.
`default_nettype none

package n7s_pkg;

	// Input item: signed fixed-point value, wanted fraction digits and radix.
	typedef struct packed {
		logic signed [47:0] value;
		logic [2:0]         frac_digits;
		logic [4:0]         radix;
	} num_item_t;

	// Result item: four display positions and the error flag.
	typedef struct packed {
		logic [7:0] seg_pos0;
		logic [7:0] seg_pos1;
		logic [7:0] seg_pos2;
		logic [7:0] seg_pos3;
		logic       overflow_error;
	} seg_item_t;

	// Classified job handed from the front part to the back part.
	typedef struct packed {
		logic        neg;
		logic [47:0] mag;
		logic [2:0]  frac;
		logic [4:0]  radix;
	} job_t;

	localparam logic [7:0] SEG_BLANK   = 8'h00;
	localparam logic [7:0] SEG_MINUS   = 8'h40;
	localparam logic [7:0] SEG_DOT     = 8'h80;
	localparam logic [7:0] SEG_LOWER_R = 8'h50;
	localparam logic [7:0] SEG_E       = 8'h79;

	// Segment pattern of one hex digit.
	function automatic logic [7:0] hex_seg(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'h0: s = 8'h3F;
			4'h1: s = 8'h06;
			4'h2: s = 8'h5B;
			4'h3: s = 8'h4F;
			4'h4: s = 8'h66;
			4'h5: s = 8'h6D;
			4'h6: s = 8'h7D;
			4'h7: s = 8'h07;
			4'h8: s = 8'h7F;
			4'h9: s = 8'h6F;
			4'hA: s = 8'h77;
			4'hB: s = 8'h7C;
			4'hC: s = 8'h39;
			4'hD: s = 8'h5E;
			4'hE: s = 8'h79;
			default: s = 8'h71;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

>>> rtl/number_to_seven_segment_formatter.sv
// Top level of the seven-segment number formatter: front, queue and back.
//
//   channel   handshake              payload     direction
//   number    num_valid/num_ready    num_item    into the block
//   segments  seg_valid/seg_ready    seg_item    out of the block
//
// The fit test allows DIGIT_COUNT digits (one less if negative), and the radix
// divider retires four quotient bits a cycle. Reset clears all control state;
// the queue holds two jobs so the front keeps accepting while the back works,
// and a result waits in the output register.
`default_nettype none

module number_to_seven_segment_formatter import n7s_pkg::*; #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      num_valid,
	output logic      num_ready,
	input  num_item_t num_item,
	output logic      seg_valid,
	input  logic      seg_ready,
	output seg_item_t seg_item
);

	logic fq_valid;
	logic fq_ready;
	job_t fq_job;
	logic qb_valid;
	logic qb_ready;
	job_t qb_job;

	n7s_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num_valid),
		.num_ready (num_ready),
		.num_item  (num_item),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	n7s_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_job   (fq_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_job    (qb_job)
	);

	n7s_back #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_job),
		.seg_valid (seg_valid),
		.seg_ready (seg_ready),
		.seg_item  (seg_item)
	);

`ifndef NO_ASSERTIONS
	// An error result carries the error pattern on positions 0, 1 and 3.
	a_err_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_item.overflow_error |->
			seg_item.seg_pos0 == SEG_E && seg_item.seg_pos1 == SEG_LOWER_R &&
			seg_item.seg_pos3 == SEG_BLANK)
		else $error("error result without error pattern");

	// The rightmost digit is never given the decimal point.
	a_no_dot_right: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_item.overflow_error |-> !seg_item.seg_pos3[7])
		else $error("dot on rightmost position");
`endif

endmodule

`default_nettype wire

>>> rtl/n7s_front.sv
// Front part: accepts input items, takes sign and magnitude and clamps the radix.
`default_nettype none

module n7s_front import n7s_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      num_valid,
	output logic      num_ready,
	input  num_item_t num_item,
	output logic      job_valid,
	input  logic      job_ready,
	output job_t      job
);

	logic        job_valid_s1;
	job_t        job_s1;
	job_t        job_c;
	logic [47:0] raw;

	// Classify the incoming item.
	always_comb begin
		raw       = num_item.value;
		job_c.neg = raw[47];
		job_c.mag = raw[47] ? (~raw + 48'd1) : raw;
		job_c.frac = num_item.frac_digits;
		if (num_item.radix < 5'd2) begin
			job_c.radix = 5'd2;
		end else if (num_item.radix > 5'd16) begin
			job_c.radix = 5'd16;
		end else begin
			job_c.radix = num_item.radix;
		end
	end

	assign num_ready = !job_valid_s1 || job_ready;

	// Stage register toward the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
		end else if (num_ready) begin
			job_valid_s1 <= num_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (num_valid && num_ready) begin
			job_s1 <= job_c;
		end
	end

	assign job_valid = job_valid_s1;
	assign job       = job_s1;

endmodule

`default_nettype wire

>>> rtl/n7s_queue.sv
// Two-entry job queue between the front and back parts.
`default_nettype none

module n7s_queue import n7s_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_job    = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

>>> rtl/n7s_back.sv
// Back part: scaling search, digit extraction by radix and the output register.
`default_nettype none

module n7s_back import n7s_pkg::*; #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	output logic      job_ready,
	input  job_t      job,
	output logic      seg_valid,
	input  logic      seg_ready,
	output seg_item_t seg_item
);

	localparam int NW  = 4 * DIGIT_COUNT;
	localparam int TBW = NW + 1;
	localparam int PW  = (NW + 20 > 48) ? NW + 20 : 48;
	localparam int CW  = $clog2(DIGIT_COUNT + 1);
	localparam int PIW = $clog2(DIGIT_COUNT);
	localparam int SW  = $clog2(DIGIT_COUNT);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POW,
		ST_SCALE,
		ST_DIV,
		ST_SIGN,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic            neg_q;
	logic [2:0]      frac_q;
	logic [4:0]      rad_q;
	logic [PW-1:0]   p_q;
	logic [TBW-1:0]  tb_q;
	logic [CW-1:0]   cnt_q;
	logic [2:0]      k_q;
	logic [2:0]      fk_q;
	logic            found_q;
	logic            err_q;
	logic [NW-1:0]   num_q;
	logic [3:0]      rem_q;
	logic [SW-1:0]   step_q;
	logic [2:0]      dig_q;
	logic [PIW-1:0]  pos_q;
	logic [7:0]      buf_q [DIGIT_COUNT];
	logic            out_valid_q;
	seg_item_t       out_q;

	logic [PW:0]     rnd;
	logic [PW-16:0]  r;
	logic            fits;
	logic [PW+4:0]   pmul;
	logic [TBW+4:0]  tbmul;
	logic [4:0]      rem;
	logic [3:0]      qb;
	logic [NW-1:0]   num_n;
	logic [7:0]      dseg;
	logic [7:0]      vis [4];
	seg_item_t       built;

	// Rounded scaled value and the fit test against radix^avail.
	always_comb begin
		rnd  = {1'b0, p_q} + (PW+1)'(32768);
		r    = rnd[PW:16];
		fits = (r < (PW-15)'(tb_q));
		pmul  = p_q * rad_q;
		tbmul = tb_q * rad_q;
	end

	// Four restoring division steps by the radix per cycle.
	always_comb begin
		rem = {1'b0, rem_q};
		qb  = 4'd0;
		for (int j = 0; j < 4; j++) begin
			rem = {rem[3:0], num_q[NW-1-j]};
			if (rem >= rad_q) begin
				rem       = rem - rad_q;
				qb[3-j]   = 1'b1;
			end
		end
		num_n = {num_q[NW-5:0], qb};
		dseg  = hex_seg(rem[3:0]);
		if (fk_q != 3'd0 && dig_q == fk_q) begin
			dseg = dseg | SEG_DOT;
		end
	end

	// Visible positions; those past the digit count stay blank.
	for (genvar g = 0; g < 4; g++) begin : g_vis
		if (g < DIGIT_COUNT) begin : g_on
			assign vis[g] = buf_q[g];
		end else begin : g_off
			assign vis[g] = SEG_BLANK;
		end
	end

	always_comb begin
		if (err_q) begin
			built.seg_pos0       = SEG_E;
			built.seg_pos1       = SEG_LOWER_R;
			built.seg_pos2       = SEG_LOWER_R | SEG_DOT;
			built.seg_pos3       = SEG_BLANK;
			built.overflow_error = 1'b1;
		end else begin
			built.seg_pos0       = vis[0];
			built.seg_pos1       = vis[1];
			built.seg_pos2       = vis[2];
			built.seg_pos3       = vis[3];
			built.overflow_error = 1'b0;
		end
	end

	assign job_ready = (state_q == ST_IDLE);
	assign seg_valid = out_valid_q;
	assign seg_item  = out_q;

	// Sequencer with its working registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			neg_q       <= 1'b0;
			frac_q      <= 3'd0;
			rad_q       <= 5'd2;
			p_q         <= '0;
			tb_q        <= '0;
			cnt_q       <= '0;
			k_q         <= 3'd0;
			fk_q        <= 3'd0;
			found_q     <= 1'b0;
			err_q       <= 1'b0;
			num_q       <= '0;
			rem_q       <= 4'd0;
			step_q      <= '0;
			dig_q       <= 3'd0;
			pos_q       <= '0;
			out_q       <= '0;
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				buf_q[i] <= SEG_BLANK;
			end
		end else begin
			if (out_valid_q && seg_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						neg_q   <= job.neg;
						frac_q  <= job.frac;
						rad_q   <= job.radix;
						p_q     <= PW'(job.mag);
						tb_q    <= TBW'(1);
						cnt_q   <= job.neg ? CW'(DIGIT_COUNT - 1) : CW'(DIGIT_COUNT);
						k_q     <= 3'd0;
						found_q <= 1'b0;
						err_q   <= 1'b0;
						rem_q   <= 4'd0;
						step_q  <= '0;
						dig_q   <= 3'd0;
						pos_q   <= PIW'(DIGIT_COUNT - 1);
						for (int i = 0; i < DIGIT_COUNT; i++) begin
							buf_q[i] <= SEG_BLANK;
						end
						state_q <= ST_POW;
					end
				end
				ST_POW: begin
					if (cnt_q == '0) begin
						state_q <= ST_SCALE;
					end else begin
						tb_q  <= tbmul[TBW-1:0];
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_SCALE: begin
					if (fits) begin
						num_q   <= r[NW-1:0];
						fk_q    <= k_q;
						found_q <= 1'b1;
						if (k_q == frac_q) begin
							state_q <= ST_DIV;
						end else begin
							p_q <= pmul[PW-1:0];
							k_q <= k_q + 3'd1;
						end
					end else if (found_q) begin
						state_q <= ST_DIV;
					end else begin
						err_q   <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					num_q <= num_n;
					if (step_q == SW'(DIGIT_COUNT - 1)) begin
						buf_q[pos_q] <= dseg;
						pos_q        <= pos_q - PIW'(1);
						dig_q        <= dig_q + 3'd1;
						step_q       <= '0;
						rem_q        <= 4'd0;
						if (num_n == '0) begin
							state_q <= ST_SIGN;
						end
					end else begin
						rem_q  <= rem[3:0];
						step_q <= step_q + SW'(1);
					end
				end
				ST_SIGN: begin
					if (neg_q) begin
						buf_q[pos_q] <= SEG_MINUS;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || seg_ready) begin
						out_valid_q <= 1'b1;
						out_q       <= built;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
